>>> sv/iaid_pkg.sv
// Shared constants and types for the indexed array insert/delete block.
package iaid_pkg;

    // Field widths of the channel items.
    localparam int CMD_W    = 2;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int RIDX_W   = 6;
    localparam int FILL_W   = 7;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BADPOS = 2'd3;

    // Control broadcast from the sequencer to every cell of the row.
    typedef struct packed {
        logic             insert_en;
        logic             delete_en;
        logic             rotate_en;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] last_idx;
    } cell_ctrl_t;

endpackage

>>> sv/iaid_if.sv
// Valid/ready channel interfaces for the command input and the result output.
interface iaid_in_if;
    logic                               valid;
    logic                               ready;
    logic [iaid_pkg::CMD_W-1:0]         cmd;
    logic [iaid_pkg::POS_W-1:0]         position;
    logic signed [iaid_pkg::DATA_W-1:0] new_value;

    modport source (output valid, output cmd, output position, output new_value,
                    input ready);
    modport sink (input valid, input cmd, input position, input new_value,
                  output ready);
endinterface

interface iaid_out_if;
    logic                               valid;
    logic                               ready;
    logic [iaid_pkg::STATUS_W-1:0]      status;
    logic signed [iaid_pkg::DATA_W-1:0] read_value;
    logic [iaid_pkg::RIDX_W-1:0]        read_index;
    logic [iaid_pkg::FILL_W-1:0]        fill_count;
    logic                               last;

    modport source (output valid, output status, output read_value,
                    output read_index, output fill_count, output last,
                    input ready);
    modport sink (input valid, input status, input read_value,
                  input read_index, input fill_count, input last,
                  output ready);
endinterface

>>> sv/iaid_cell.sv
// One storage cell of the list row: holds one entry and trades it with its neighbors.
module iaid_cell #(
    parameter int IDX = 0
) (
    input  logic                               clk,
    input  iaid_pkg::cell_ctrl_t               ctrl,
    input  logic signed [iaid_pkg::DATA_W-1:0] new_value,
    input  logic signed [iaid_pkg::DATA_W-1:0] lower_value,
    input  logic signed [iaid_pkg::DATA_W-1:0] upper_value,
    input  logic signed [iaid_pkg::DATA_W-1:0] wrap_value,
    output logic signed [iaid_pkg::DATA_W-1:0] value
);

    localparam logic [iaid_pkg::POS_W-1:0] MY_IDX = iaid_pkg::POS_W'(IDX);

    logic signed [iaid_pkg::DATA_W-1:0] value_reg;
    logic signed [iaid_pkg::DATA_W-1:0] value_next;

    // Pick the next content: new word, a neighbor's word, the wrapped head, or hold.
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert_en)
        begin
            if (MY_IDX == ctrl.pos)
            begin
                value_next = new_value;
            end
            else if (MY_IDX > ctrl.pos)
            begin
                value_next = lower_value;
            end
        end
        else if (ctrl.delete_en)
        begin
            if (MY_IDX >= ctrl.pos)
            begin
                value_next = upper_value;
            end
        end
        else if (ctrl.rotate_en)
        begin
            if (MY_IDX == ctrl.last_idx)
            begin
                value_next = wrap_value;
            end
            else if (MY_IDX < ctrl.last_idx)
            begin
                value_next = upper_value;
            end
        end
    end

    // Entry storage needs no reset; it is undefined until written.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

>>> sv/indexed_array_insert_delete.sv
// Top level of the indexed array insert/delete block: cell row plus command sequencer.
//
// The block keeps a packed ordered list of signed 32-bit words, up to DEPTH of them.
// Commands arrive on in_ch (cmd, position, new_value); results leave on out_ch
// (status, read_value, read_index, fill_count, last), valid/ready on both sides.
// Insert and delete each give one result, and the whole row of cells shifts at
// once, so these commands can be accepted on every cycle while the receiver takes results.
// A dump of N entries gives N results, marked last on the final one. The row
// rotates one place per result so that the head cell always holds the next
// entry; after N rotations the list is back in its original order. No command
// is accepted during a dump. Failed commands (full, empty, bad position, unknown
// code) give a single result with the status code and change nothing.
// Results pass through a one-item output register. When the receiver stalls, the
// register holds its item and the block stops taking commands and stops rotating,
// so nothing is lost. Reset empties the list at once (the fill count goes to zero);
// the entry cells themselves are not cleared.
module indexed_array_insert_delete #(
    parameter int DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    iaid_in_if.sink           in_ch,
    iaid_out_if.source        out_ch
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [iaid_pkg::POS_W-1:0] DEPTH_P = iaid_pkg::POS_W'(DEPTH);

    typedef enum logic [1:0] {
        S_CMD  = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t                             state_reg, state_next;
    logic [CNT_W-1:0]                   occ_reg, occ_next;
    logic [IDX_W-1:0]                   dump_idx_reg, dump_idx_next;

    logic                               out_valid_reg, out_valid_next;
    logic [iaid_pkg::STATUS_W-1:0]      status_reg, status_next;
    logic signed [iaid_pkg::DATA_W-1:0] read_value_reg, read_value_next;
    logic [iaid_pkg::RIDX_W-1:0]        read_index_reg, read_index_next;
    logic [iaid_pkg::FILL_W-1:0]        fill_count_reg, fill_count_next;
    logic                               last_reg, last_next;

    logic                               out_free;
    logic                               in_fire;
    logic                               dump_last;
    logic [iaid_pkg::POS_W-1:0]         occ_w;
    iaid_pkg::cell_ctrl_t               ctrl;
    logic signed [iaid_pkg::DATA_W-1:0] cell_values [DEPTH];

    assign occ_w     = iaid_pkg::POS_W'(occ_reg);
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == S_CMD) && out_free;
    assign in_fire   = in_ch.valid && in_ch.ready;
    assign dump_last = (iaid_pkg::POS_W'(dump_idx_reg) == occ_w - 7'd1);

    // Row of cells; each sees its lower and upper neighbor and the head cell.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [iaid_pkg::DATA_W-1:0] lower_v;
        logic signed [iaid_pkg::DATA_W-1:0] upper_v;
        if (i == 0)
        begin : g_first
            assign lower_v = in_ch.new_value;
        end
        else
        begin : g_mid_lo
            assign lower_v = cell_values[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_end
            assign upper_v = cell_values[i];
        end
        else
        begin : g_mid_hi
            assign upper_v = cell_values[i+1];
        end
        iaid_cell #(
            .IDX (i)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_value   (in_ch.new_value),
            .lower_value (lower_v),
            .upper_value (upper_v),
            .wrap_value  (cell_values[0]),
            .value       (cell_values[i])
        );
    end

    // Command decode, dump sequencing and result formation.
    always_comb
    begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        dump_idx_next   = dump_idx_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        status_next     = status_reg;
        read_value_next = read_value_reg;
        read_index_next = read_index_reg;
        fill_count_next = fill_count_reg;
        last_next       = last_reg;
        ctrl.insert_en  = 1'b0;
        ctrl.delete_en  = 1'b0;
        ctrl.rotate_en  = 1'b0;
        ctrl.pos        = in_ch.position;
        ctrl.last_idx   = occ_w - 7'd1;

        unique case (state_reg)
            S_CMD:
            begin
                if (in_fire)
                begin
                    read_value_next = '0;
                    read_index_next = '0;
                    last_next       = 1'b1;
                    out_valid_next  = 1'b1;
                    status_next     = iaid_pkg::STATUS_OK;
                    unique case (in_ch.cmd)
                        iaid_pkg::CMD_INSERT:
                        begin
                            if (occ_w >= DEPTH_P)
                            begin
                                status_next = iaid_pkg::STATUS_FULL;
                            end
                            else if (in_ch.position > occ_w)
                            begin
                                status_next = iaid_pkg::STATUS_BADPOS;
                            end
                            else
                            begin
                                ctrl.insert_en = 1'b1;
                                occ_next       = occ_reg + CNT_W'(1);
                            end
                        end
                        iaid_pkg::CMD_DELETE:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = iaid_pkg::STATUS_EMPTY;
                            end
                            else if (in_ch.position >= occ_w)
                            begin
                                status_next = iaid_pkg::STATUS_BADPOS;
                            end
                            else
                            begin
                                ctrl.delete_en = 1'b1;
                                occ_next       = occ_reg - CNT_W'(1);
                            end
                        end
                        iaid_pkg::CMD_DUMP:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = iaid_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                // Results come from the dump state instead.
                                out_valid_next = out_valid_reg && !out_ch.ready;
                                dump_idx_next  = '0;
                                state_next     = S_DUMP;
                            end
                        end
                        default:
                        begin
                            status_next = iaid_pkg::STATUS_BADPOS;
                        end
                    endcase
                    fill_count_next = iaid_pkg::FILL_W'(occ_next);
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = iaid_pkg::STATUS_OK;
                    read_value_next = cell_values[0];
                    read_index_next = iaid_pkg::RIDX_W'(dump_idx_reg);
                    fill_count_next = iaid_pkg::FILL_W'(occ_reg);
                    last_next       = dump_last;
                    ctrl.rotate_en  = 1'b1;
                    dump_idx_next   = dump_idx_reg + IDX_W'(1);
                    if (dump_last)
                    begin
                        state_next = S_CMD;
                    end
                end
            end
            default:
            begin
                state_next = S_CMD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CMD;
            occ_reg       <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            dump_idx_reg  <= dump_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        read_value_reg <= read_value_next;
        read_index_reg <= read_index_next;
        fill_count_reg <= fill_count_next;
        last_reg       <= last_next;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.status     = status_reg;
    assign out_ch.read_value = read_value_reg;
    assign out_ch.read_index = read_index_reg;
    assign out_ch.fill_count = fill_count_reg;
    assign out_ch.last       = last_reg;

    // The list never holds more entries than there are cells.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_w <= DEPTH_P)
        else $error("occupancy exceeds the cell count");

    // During a dump the read pointer stays inside the held entries.
    a_dump_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |-> (iaid_pkg::POS_W'(dump_idx_reg) < occ_w))
        else $error("dump index beyond occupancy");

    // A successful insert grows the list by exactly one.
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.insert_en |=> (occ_reg == $past(occ_reg) + CNT_W'(1)))
        else $error("insert did not grow the list by one");

    // The final dump result hands control back to command intake.
    a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP && out_free && dump_last) |=>
        (state_reg == S_CMD && out_ch.valid && out_ch.last))
        else $error("dump did not end after the last entry");

endmodule

>>> dv/tb_indexed_array_insert_delete.sv
// Self-checking testbench for the indexed array insert/delete block.
module tb_indexed_array_insert_delete;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH   = 64;
    localparam int IDLE_PCT     = 18;
    localparam int RANDOM_ITEMS = 360;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 400_000;

    // Command code that the block does not define; it must answer bad position.
    localparam logic [iaid_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [iaid_pkg::STATUS_W-1:0]      status;
        logic signed [iaid_pkg::DATA_W-1:0] read_value;
        logic [iaid_pkg::RIDX_W-1:0]        read_index;
        logic [iaid_pkg::FILL_W-1:0]        fill_count;
        logic                               last;
    } list_result_t;

    typedef enum {TRAFFIC_GROW, TRAFFIC_SHRINK, TRAFFIC_BALANCED} traffic_mode_t;

    // Tracks the list contents and holds the results still owed by the block.
    class list_board;
        logic signed [iaid_pkg::DATA_W-1:0] cells[LIST_DEPTH];
        int unsigned                        count;
        list_result_t                       pending_results[$];
        int                                 errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function void add_result(logic [iaid_pkg::STATUS_W-1:0] status,
                                 logic signed [iaid_pkg::DATA_W-1:0] value,
                                 logic [iaid_pkg::RIDX_W-1:0] index, logic fin);
            list_result_t r;
            r.status     = status;
            r.read_value = value;
            r.read_index = index;
            r.fill_count = count[iaid_pkg::FILL_W-1:0];
            r.last       = fin;
            pending_results.push_back(r);
        endfunction

        // Applies one accepted command to the list and queues its results.
        function void note_command(logic [iaid_pkg::CMD_W-1:0] cmd,
                                   logic [iaid_pkg::POS_W-1:0] pos,
                                   logic signed [iaid_pkg::DATA_W-1:0] value);
            case (cmd)
                iaid_pkg::CMD_INSERT:
                begin
                    if (count >= LIST_DEPTH)
                        add_result(iaid_pkg::STATUS_FULL, '0, '0, 1'b1);
                    else if (pos > count)
                        add_result(iaid_pkg::STATUS_BADPOS, '0, '0, 1'b1);
                    else
                    begin
                        for (int i = count; i > pos; i--)
                            cells[i] = cells[i-1];
                        cells[pos] = value;
                        count++;
                        add_result(iaid_pkg::STATUS_OK, '0, '0, 1'b1);
                    end
                end
                iaid_pkg::CMD_DELETE:
                begin
                    if (count == 0)
                        add_result(iaid_pkg::STATUS_EMPTY, '0, '0, 1'b1);
                    else if (pos >= count)
                        add_result(iaid_pkg::STATUS_BADPOS, '0, '0, 1'b1);
                    else
                    begin
                        for (int i = pos; i + 1 < count; i++)
                            cells[i] = cells[i+1];
                        count--;
                        add_result(iaid_pkg::STATUS_OK, '0, '0, 1'b1);
                    end
                end
                iaid_pkg::CMD_DUMP:
                begin
                    if (count == 0)
                        add_result(iaid_pkg::STATUS_EMPTY, '0, '0, 1'b1);
                    else
                        for (int i = 0; i < count; i++)
                            add_result(iaid_pkg::STATUS_OK, cells[i],
                                       i[iaid_pkg::RIDX_W-1:0], i + 1 == count);
                end
                default:
                    add_result(iaid_pkg::STATUS_BADPOS, '0, '0, 1'b1);
            endcase
        endfunction

        // Compares one accepted result with the oldest one still owed.
        function void check_result(list_result_t got);
            list_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result with none expected: status %0d value %0d index %0d",
                       got.status, got.read_value, got.read_index);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.read_value !== want.read_value)
            begin
                $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
                errors++;
            end
            if (got.read_index !== want.read_index)
            begin
                $error("read_index: expected %0d, got %0d", want.read_index, got.read_index);
                errors++;
            end
            if (got.fill_count !== want.fill_count)
            begin
                $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   random_done;

    list_board board;

    iaid_in_if  in_ch ();
    iaid_out_if out_ch ();

    indexed_array_insert_delete #(
        .DEPTH (LIST_DEPTH)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Presents one command, with random idle cycles ahead of it, until it is taken.
    task automatic send_item(input logic [iaid_pkg::CMD_W-1:0] cmd,
                             input logic [iaid_pkg::POS_W-1:0] pos,
                             input logic signed [iaid_pkg::DATA_W-1:0] value);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= cmd;
        in_ch.position  <= pos;
        in_ch.new_value <= value;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        board.note_command(cmd, pos, value);
    endtask

    // Mostly random words, with the extremes mixed in now and then.
    function automatic logic signed [iaid_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(19))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom();
        endcase
    endfunction

    // One random command; the mode biases the list toward growing or shrinking.
    task automatic random_item(input traffic_mode_t mode);
        int unsigned                roll;
        int unsigned                ins_lim;
        int unsigned                del_lim;
        int unsigned                fill;
        logic [iaid_pkg::CMD_W-1:0] cmd;
        logic [iaid_pkg::POS_W-1:0] pos;
        case (mode)
            TRAFFIC_GROW:   begin ins_lim = 70; del_lim = 82; end
            TRAFFIC_SHRINK: begin ins_lim = 12; del_lim = 82; end
            default:        begin ins_lim = 40; del_lim = 80; end
        endcase
        fill = board.count;
        roll = $urandom_range(99);
        if (roll < ins_lim)
        begin
            cmd = iaid_pkg::CMD_INSERT;
            pos = iaid_pkg::POS_W'($urandom_range(fill));
        end
        else if (roll < del_lim)
        begin
            cmd = iaid_pkg::CMD_DELETE;
            pos = (fill > 0) ? iaid_pkg::POS_W'($urandom_range(fill - 1))
                             : iaid_pkg::POS_W'($urandom_range(127));
        end
        else if (roll < del_lim + 9)
        begin
            cmd = iaid_pkg::CMD_DUMP;
            pos = iaid_pkg::POS_W'($urandom_range(127));
        end
        else
        begin
            // Noise: out-of-range positions and the undefined command code.
            case ($urandom_range(2))
                0:
                begin
                    cmd = iaid_pkg::CMD_INSERT;
                    pos = iaid_pkg::POS_W'($urandom_range(127, fill + 1));
                end
                1:
                begin
                    cmd = iaid_pkg::CMD_DELETE;
                    pos = iaid_pkg::POS_W'($urandom_range(127, fill));
                end
                default:
                begin
                    cmd = CMD_UNUSED;
                    pos = iaid_pkg::POS_W'($urandom_range(127));
                end
            endcase
        end
        send_item(cmd, pos, pick_value());
        random_done++;
    endtask

    // Result side: random back-pressure and a check of every accepted result.
    initial
    begin
        list_result_t got;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                got.status     = out_ch.status;
                got.read_value = out_ch.read_value;
                got.read_index = out_ch.read_index;
                got.fill_count = out_ch.fill_count;
                got.last       = out_ch.last;
                board.check_result(got);
            end
            out_ch.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Guard against a hung block.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    // Main sequence: reset, directed cases, then biased random traffic.
    initial
    begin
        board       = new();
        idle_on     = 1'b1;
        random_done = 0;
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.cmd       <= iaid_pkg::CMD_INSERT;
        in_ch.position  <= '0;
        in_ch.new_value <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list: dump and delete report empty even with a wild position.
        send_item(iaid_pkg::CMD_DUMP, 7'd0, 32'sd0);
        send_item(iaid_pkg::CMD_DELETE, 7'd0, 32'sd0);
        send_item(iaid_pkg::CMD_DELETE, 7'd127, -32'sd1);
        // Insert past the count on an empty list.
        send_item(iaid_pkg::CMD_INSERT, 7'd1, 32'sd5);
        send_item(iaid_pkg::CMD_INSERT, 7'd127, 32'sd5);
        // Build a small list: front, end and middle inserts with extreme words.
        send_item(iaid_pkg::CMD_INSERT, 7'd0, 32'sh7FFF_FFFF);
        send_item(iaid_pkg::CMD_INSERT, 7'd0, 32'sh8000_0000);
        send_item(iaid_pkg::CMD_INSERT, 7'd2, -32'sd1);
        send_item(iaid_pkg::CMD_INSERT, 7'd1, 32'sd0);
        send_item(iaid_pkg::CMD_INSERT, 7'd4, 32'sh5555_5555);
        send_item(iaid_pkg::CMD_INSERT, 7'd2, 32'shAAAA_AAAA);
        send_item(iaid_pkg::CMD_DUMP, 7'd127, 32'sd0);
        // The undefined command code changes nothing.
        send_item(CMD_UNUSED, 7'd0, 32'sd0);
        send_item(CMD_UNUSED, 7'd127, -32'sd1);
        // Delete at and past the end, then front, end and middle.
        send_item(iaid_pkg::CMD_DELETE, 7'd6, 32'sd0);
        send_item(iaid_pkg::CMD_DELETE, 7'd127, 32'sd0);
        send_item(iaid_pkg::CMD_DELETE, 7'd0, 32'sd0);
        send_item(iaid_pkg::CMD_DELETE, 7'd4, 32'sd0);
        send_item(iaid_pkg::CMD_DELETE, 7'd1, 32'sd0);
        send_item(iaid_pkg::CMD_INSERT, 7'd4, 32'sd9);
        send_item(iaid_pkg::CMD_DUMP, 7'd0, 32'sd0);

        // Fill the list, then hit it while full, including with bad positions.
        while (board.count < LIST_DEPTH)
            random_item(TRAFFIC_GROW);
        send_item(iaid_pkg::CMD_INSERT, 7'd0, pick_value());
        send_item(iaid_pkg::CMD_INSERT, 7'd64, pick_value());
        send_item(iaid_pkg::CMD_INSERT, 7'd65, pick_value());
        send_item(iaid_pkg::CMD_INSERT, 7'd127, pick_value());
        send_item(iaid_pkg::CMD_DUMP, 7'd0, 32'sd0);
        send_item(iaid_pkg::CMD_DELETE, 7'd64, 32'sd0);
        send_item(iaid_pkg::CMD_DELETE, 7'd63, 32'sd0);

        // A stretch with no idling on either side.
        idle_on = 1'b0;
        repeat (60) random_item(TRAFFIC_BALANCED);
        idle_on = 1'b1;

        // Drain to empty and poke the empty list again.
        while (board.count > 0)
            random_item(TRAFFIC_SHRINK);
        send_item(iaid_pkg::CMD_DELETE, 7'd0, 32'sd0);
        send_item(iaid_pkg::CMD_DUMP, 7'd0, 32'sd0);

        while (random_done < RANDOM_ITEMS)
            random_item(TRAFFIC_BALANCED);
        in_ch.valid <= 1'b0;

        // Wait for every owed result, then a little longer for strays.
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
